// ----- src/dsu_pkg.sv -----
// ----------------------------------------------------------------------------
// dsu_pkg: shared types and constants for the deduplicating set union
// Word formats for both channels and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int CAPACITY   = 256;
  localparam int POINT_BITS = 16;

  // Width of the point field on the input channel
  localparam int POINT_W = 16;
  // Width of the union_count field on the output channel
  localparam int UCOUNT_W = 9;

  // Bits of a point that take part in the compare
  localparam int KEY_W = (POINT_BITS < POINT_W) ? POINT_BITS : POINT_W;
  // Entry index and entry count widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic               last_of_merge;
  } in_word_t;

  typedef struct packed {
    logic                added;
    logic                duplicate;
    logic                dropped;
    logic [UCOUNT_W-1:0] union_count;
    logic                merge_done;
  } out_word_t;

  // Query token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic             added;
    logic             last;
  } token_t;

endpackage

// ----- src/dsu_cell.sv -----
// ----------------------------------------------------------------------------
// dsu_cell: one entry of the union store
// Holds one point, compares it with the passing token and appends the
// token's point when this cell is the first free slot and no earlier cell matched.
// ----------------------------------------------------------------------------
module dsu_cell
  import dsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CNT_W-1:0] count_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  logic [KEY_W-1:0] entry_q;
  token_t           tok_q;
  token_t           tok_d;
  logic             ent_valid;
  logic             match;
  logic             wr_en;

  assign ent_valid = CNT_W'(idx_i) < count_i;
  assign match     = tok_i.vld && ent_valid && (entry_q == tok_i.key);
  // All valid entries sit left of the free slot, so hit is final here
  assign wr_en     = tok_i.vld && !tok_i.hit && (CNT_W'(idx_i) == count_i);

  always_comb begin
    tok_d       = tok_i;
    tok_d.hit   = tok_i.hit | match;
    tok_d.added = tok_i.added | wr_en;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= tok_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- src/dedup_set_union.sv -----
// ----------------------------------------------------------------------------
// dedup_set_union: streaming union of point sets without duplicates
// Top level: input register, chain of entry cells, result and output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one point per
//   word; last_of_merge marks the final point of a merge. Output channel
//   (out_valid_o / out_stall_i / out_word_o) returns one result word per
//   point: added, duplicate or dropped, the running union count and the
//   echoed last marker. After a last word the count returns to zero.
//   Each point enters a register, then walks the row of CAPACITY cells one
//   cell per cycle; every cell compares it with its stored point and the
//   first free cell appends it. From the end of the row the result passes a
//   pending register and then the output register.
//   One point is in the row at a time: the next word is taken once the
//   previous result has moved into the output register.
//   A stalled result waits in the output register while the next point
//   already walks the row; a second finished result holds in a pending
//   register until the output frees up.
//   Reset clears the count and all control state; stored points need none.
// ----------------------------------------------------------------------------
module dedup_set_union
  import dsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic             busy_q;
  logic             busy_d;
  token_t           tok_in_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] count_nx;
  logic [31:0]      count_ext;
  out_word_t        pend_q;
  out_word_t        pend_d;
  logic             pend_vld_q;
  logic             pend_vld_d;
  out_word_t        out_q;
  logic             out_vld_q;
  logic             out_vld_d;
  logic             in_acc;
  logic             out_load;
  token_t           tok_exit;
  token_t           tok_chain [CAPACITY+1];
  logic [CAPACITY-1:0] chain_vld;

  assign in_acc   = in_valid_i && !busy_q;
  assign out_load = pend_vld_q && (!out_vld_q || !out_stall_i);

  // Inject register feeding the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_in_q <= '0;
    end else if (in_acc) begin
      tok_in_q <= '{vld:   1'b1,
                    key:   in_word_i.point[KEY_W-1:0],
                    hit:   1'b0,
                    added: 1'b0,
                    last:  in_word_i.last_of_merge};
    end else begin
      tok_in_q.vld <= 1'b0;
    end
  end

  assign tok_chain[0] = tok_in_q;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    dsu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(k)),
      .count_i (count_q),
      .tok_i   (tok_chain[k]),
      .tok_o   (tok_chain[k+1])
    );
    assign chain_vld[k] = tok_chain[k+1].vld;
  end

  assign tok_exit  = tok_chain[CAPACITY];
  assign count_nx  = count_q + CNT_W'(tok_exit.added);
  assign count_ext = 32'(count_nx);

  always_comb begin
    busy_d     = busy_q;
    count_d    = count_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = out_vld_q;

    if (in_acc) begin
      busy_d = 1'b1;
    end
    if (out_load) begin
      pend_vld_d = 1'b0;
      busy_d     = 1'b0;
      out_vld_d  = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (tok_exit.vld) begin
      pend_vld_d         = 1'b1;
      pend_d.added       = tok_exit.added;
      pend_d.duplicate   = tok_exit.hit;
      pend_d.dropped     = !tok_exit.hit && !tok_exit.added;
      pend_d.union_count = count_ext[UCOUNT_W-1:0];
      pend_d.merge_done  = tok_exit.last;
      // End of merge: drop all entries
      count_d = tok_exit.last ? '0 : count_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one token in the cell row");

  a_busy_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_in_q.vld || (chain_vld != '0) || pend_vld_q) |-> busy_q)
    else $error("word in flight while not busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_exit.vld && !tok_exit.hit && !tok_exit.added) |-> count_q == CNT_W'(CAPACITY))
    else $error("point dropped while store not full");
`endif

endmodule

// ----- bench/dsu_union_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsu_union_checker: result checker for the deduplicating set union
// Watches both channels, keeps its own copy of the union to predict each
// result word, and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module dsu_union_checker
  import dsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        outstanding_o
);

  localparam logic [POINT_W-1:0] KEY_MASK =
    (POINT_BITS >= POINT_W) ? {POINT_W{1'b1}} : POINT_W'((64'd1 << POINT_BITS) - 64'd1);

  logic [POINT_W-1:0] union_pts [CAPACITY];
  int unsigned        union_size;
  out_word_t          expected_words [$];
  int                 fail_count;
  int                 outstanding;

  assign fail_count_o  = fail_count;
  assign outstanding_o = outstanding;

  // Fold one point into the union and return the result word it should give
  task automatic merge_point(input in_word_t w, output out_word_t r);
    logic [POINT_W-1:0] key;
    logic               hit;
    key = w.point & KEY_MASK;
    hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i < union_size && union_pts[i] == key) hit = 1'b1;
    end
    r = '0;
    if (hit) begin
      r.duplicate = 1'b1;
    end else if (union_size < CAPACITY) begin
      union_pts[union_size] = key;
      union_size++;
      r.added = 1'b1;
    end else begin
      r.dropped = 1'b1;
    end
    r.union_count = UCOUNT_W'(union_size);
    r.merge_done  = w.last_of_merge;
    // count is reported before the end of a merge clears the store
    if (w.last_of_merge) union_size = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    out_word_t got_w;
    if (!rst_ni) begin
      union_size  = 0;
      fail_count  = 0;
      outstanding = 0;
      expected_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_w = out_word_i;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %p", got_w);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w.added !== exp_w.added) begin
            $error("added: expected %0d, got %0d", exp_w.added, got_w.added);
            fail_count++;
          end
          if (got_w.duplicate !== exp_w.duplicate) begin
            $error("duplicate: expected %0d, got %0d", exp_w.duplicate, got_w.duplicate);
            fail_count++;
          end
          if (got_w.dropped !== exp_w.dropped) begin
            $error("dropped: expected %0d, got %0d", exp_w.dropped, got_w.dropped);
            fail_count++;
          end
          if (got_w.union_count !== exp_w.union_count) begin
            $error("union_count: expected %0d, got %0d",
                   exp_w.union_count, got_w.union_count);
            fail_count++;
          end
          if (got_w.merge_done !== exp_w.merge_done) begin
            $error("merge_done: expected %0d, got %0d", exp_w.merge_done, got_w.merge_done);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        merge_point(in_word_i, exp_w);
        expected_words.push_back(exp_w);
      end
      outstanding = expected_words.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the deduplicating set union
// Drives short directed merges, then random merges of mixed size including
// merges that overfill the store, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import dsu_pkg::*;

  localparam int NUM_WORDS      = 1500;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 16;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  int        fail_count;
  int        outstanding;

  logic      calm = 1'b0;
  int        stall_burst = 0;
  int        idle_cycles = 0;
  int        sent = 0;
  int        fills = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  dedup_set_union u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  dsu_union_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Receiver: random stalls, rare long bursts, none during the calm stretch
  always @(negedge clk) begin
    if (calm) begin
      out_stall   <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst > 0) begin
      out_stall   <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 3999) == 0) begin
      out_stall   <= 1'b1;
      stall_burst <= $urandom_range(50, 600);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 18);
    end
  end

  // Count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL dedup_set_union");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one word after an optional gap, hold it until accepted
  task automatic send_word(input logic [POINT_W-1:0] pt, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 24) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 280) : $urandom_range(1, 4);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{point: pt, last_of_merge: last};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Fill the store with distinct points, then push new and repeated points
  task automatic fill_merge();
    logic [POINT_W-1:0] base;
    logic [POINT_W-1:0] stride;
    int                 tail;
    int                 fresh;
    base   = POINT_W'($urandom_range(0, 65535));
    stride = POINT_W'($urandom_range(0, 65535)) | POINT_W'(1);
    tail   = $urandom_range(10, 40);
    fresh  = CAPACITY;
    for (int i = 0; i < CAPACITY; i++) begin
      send_word(base + POINT_W'(i) * stride, 1'b0);
    end
    for (int t = 0; t < tail; t++) begin
      if ($urandom_range(0, 99) < 40) begin
        send_word(base + POINT_W'($urandom_range(0, CAPACITY - 1)) * stride, t == tail - 1);
      end else begin
        send_word(base + POINT_W'(fresh) * stride, t == tail - 1);
        fresh++;
      end
    end
    fills++;
  endtask

  initial begin
    logic [POINT_W-1:0] base;
    int                 len;
    int                 kind;
    int                 next_drain;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes, repeats, a repeated last word and a one-word merge
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'h5555, 1'b1);
    send_word(16'h1234, 1'b1);
    // store starts empty again after a merge ends
    send_word(16'h0000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h0001, 1'b1);
    drain_pause();

    fill_merge();
    next_drain = sent + $urandom_range(150, 400);

    while (sent < NUM_WORDS) begin
      calm = (sent >= 700 && sent < 900);
      if (sent >= next_drain) begin
        drain_pause();
        next_drain = sent + $urandom_range(150, 400);
      end
      kind = $urandom_range(0, 99);
      if (fills < 3 && kind < 6) begin
        fill_merge();
      end else begin
        // narrow pools give repeats; some merges are all wide random points
        base = POINT_W'($urandom_range(0, 65535));
        len  = (kind < 60) ? $urandom_range(1, 20) :
               (kind < 88) ? $urandom_range(20, 80) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if (kind >= 88 || $urandom_range(0, 9) == 0) begin
            send_word(POINT_W'($urandom_range(0, 65535)), i == len - 1);
          end else begin
            send_word(base + POINT_W'($urandom_range(0, 15)), i == len - 1);
          end
        end
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS dedup_set_union");
    end else begin
      $display("FAIL dedup_set_union");
    end
    $finish;
  end

endmodule
